>>> src/swrl_pkg.sv
// Shared types and constants for the sliding window rate limiter.
// Depends on nothing; swrl_ctrl, swrl_dp, the top level and the testbench import it.
package swrl_pkg;

    localparam int KEY_ENTRIES = 64;
    localparam int QUEUE_DEPTH = 128;
    localparam int KEY_W       = $clog2(KEY_ENTRIES);
    localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 8;
    localparam int RING_AW     = KEY_W + QUEUE_W;
    localparam int KEYV_W      = 33;
    localparam int HC_W        = QUEUE_W + CNT_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AUTH_MAX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUTH_WIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_API_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_API_WIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_AGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_PER = 3'd5;

    localparam logic [7:0]  RST_AUTH_MAX  = 8'd5;
    localparam logic [31:0] RST_AUTH_WIN  = 32'd60000;
    localparam logic [7:0]  RST_API_MAX   = 8'd100;
    localparam logic [31:0] RST_API_WIN   = 32'd60000;
    localparam logic [31:0] RST_CLEAN_AGE = 32'd300000;
    localparam logic [6:0]  RST_CLEAN_PER = 7'd100;

    typedef struct packed {
        logic load_req;
        logic sweep_mode;
        logic idx_clr;
        logic idx_inc;
        logic hc_rd;
        logic hc_load;
        logic st_rd;
        logic pop;
        logic free_entry;
        logic hc_wr;
        logic key_rd;
        logic key_cmp;
        logic sel_hit;
        logic sel_free;
        logic alloc;
        logic append;
        logic set_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sweep_due;
        logic idx_end;
        logic cur_valid;
        logic count_zero;
        logic too_old;
        logic found;
        logic free_found;
        logic out_free;
    } t_status;

endpackage

>>> src/swrl_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/swrl_ctrl.sv
// Sequencer for the rate limiter: sweep, key search, stamp drop, append.
// Depends on swrl_pkg.
module swrl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  swrl_pkg::t_status i_status,
    output swrl_pkg::t_cmd    o_cmd
);
    import swrl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_ENT    = 4'd2;
    localparam logic [3:0] S_HC_LD  = 4'd3;
    localparam logic [3:0] S_DROP   = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_LK_RD  = 4'd6;
    localparam logic [3:0] S_LK_CMP = 4'd7;
    localparam logic [3:0] S_LK_END = 4'd8;
    localparam logic [3:0] S_ALLOC  = 4'd9;
    localparam logic [3:0] S_APPEND = 4'd10;
    localparam logic [3:0] S_WB     = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_sweeping, n_sweeping;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sweeping <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sweeping <= n_sweeping;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sweeping     = r_sweeping;
        cmd            = '0;
        cmd.sweep_mode = r_sweeping;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                cmd.idx_clr = 1'b1;
                if (i_status.sweep_due) begin
                    n_sweeping = 1'b1;
                    n_state    = S_ENT;
                end else begin
                    n_state = S_LK_RD;
                end
            end
            S_ENT: begin
                if (i_status.idx_end) begin
                    cmd.idx_clr = 1'b1;
                    n_sweeping  = 1'b0;
                    n_state     = S_LK_RD;
                end else if (!i_status.cur_valid) begin
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.hc_rd = 1'b1;
                    n_state   = S_HC_LD;
                end
            end
            S_HC_LD: begin
                cmd.hc_load = 1'b1;
                n_state     = S_DROP;
            end
            S_DROP: begin
                if (i_status.count_zero) begin
                    if (r_sweeping) begin
                        cmd.free_entry = 1'b1;
                        cmd.idx_inc    = 1'b1;
                        n_state        = S_ENT;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    cmd.st_rd = 1'b1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.too_old) begin
                    cmd.pop = 1'b1;
                    n_state = S_DROP;
                end else if (r_sweeping) begin
                    cmd.hc_wr   = 1'b1;
                    cmd.idx_inc = 1'b1;
                    n_state     = S_ENT;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_LK_RD: begin
                if (i_status.idx_end) begin
                    n_state = S_LK_END;
                end else begin
                    cmd.key_rd = 1'b1;
                    n_state    = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                cmd.key_cmp = 1'b1;
                cmd.idx_inc = 1'b1;
                n_state     = S_LK_RD;
            end
            S_LK_END: begin
                // after a hit the entry walk reuses S_ENT with a valid entry
                if (i_status.found) begin
                    cmd.sel_hit = 1'b1;
                    n_state     = S_ENT;
                end else if (i_status.free_found) begin
                    cmd.sel_free = 1'b1;
                    n_state      = S_ALLOC;
                end else begin
                    cmd.set_full = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_ALLOC: begin
                cmd.alloc = 1'b1;
                n_state   = S_DROP;
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                n_state    = S_WB;
            end
            S_WB: begin
                cmd.hc_wr = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_sweeping = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

`ifndef ASSERT_OFF
    a_sweep_no_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweeping |-> !cmd.append && !cmd.alloc && !cmd.out_load)
        else $error("append or result during sweep");
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second item taken while busy");
    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> !o_stall)
        else $error("controller did not return to idle");
`endif

endmodule

>>> src/swrl_dp.sv
// Datapath: config registers, key/ring tables, entry pointer, result register.
// Depends on swrl_pkg and swrl_ram.
module swrl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [swrl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_limit_class,
    input  logic [31:0]                       i_client_address,
    input  logic [31:0]                       i_now_ms,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_allowed,
    output logic                              o_table_full,
    output logic [7:0]                        o_count_in_window,
    input  swrl_pkg::t_cmd                    i_cmd,
    output swrl_pkg::t_status                 o_status
);
    import swrl_pkg::*;

    logic [7:0]  r_auth_max, r_api_max;
    logic [31:0] r_auth_win, r_api_win, r_clean_age;
    logic [6:0]  r_clean_per;
    logic [6:0]  r_call_cnt;
    logic        r_sweep_due;

    logic        r_cls;
    logic [31:0] r_addr, r_now;

    logic [KEY_ENTRIES-1:0] r_valid;
    logic [KEY_W:0]         r_idx;
    logic [KEY_W-1:0]       r_hit, r_free;
    logic                   r_found, r_free_found;
    logic [QUEUE_W-1:0]     r_head;
    logic [CNT_W-1:0]       r_count;
    logic                   r_allowed, r_full;

    logic                   r_out_valid, r_out_allowed, r_out_full;
    logic [7:0]             r_out_count;

    logic [KEY_W-1:0]   idx;
    logic [KEYV_W-1:0]  key_rdata;
    logic [HC_W-1:0]    hc_rdata;
    logic [31:0]        st_rdata;
    logic [RING_AW-1:0] st_addr;
    logic [QUEUE_W-1:0] wr_pos;
    logic [31:0]        age, limit;
    logic [7:0]         max_req, eff_max;
    logic [7:0]         next_cnt;
    logic               cur_valid;

    assign idx       = r_idx[KEY_W-1:0];
    assign cur_valid = r_valid[idx];
    assign next_cnt  = {1'b0, r_call_cnt} + 8'd1;
    assign wr_pos    = r_head + r_count[QUEUE_W-1:0];
    assign st_addr   = i_cmd.append ? {idx, wr_pos} : {idx, r_head};
    assign age       = r_now - st_rdata;
    assign limit     = i_cmd.sweep_mode ? r_clean_age : (r_cls ? r_api_win : r_auth_win);
    assign max_req   = r_cls ? r_api_max : r_auth_max;
    assign eff_max   = (max_req > CNT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) : max_req;

    swrl_ram #(.WIDTH(KEYV_W), .DEPTH(KEY_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_addr  (idx),
        .i_wdata ({r_cls, r_addr}),
        .o_rdata (key_rdata)
    );

    swrl_ram #(.WIDTH(HC_W), .DEPTH(KEY_ENTRIES)) u_hc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hc_wr),
        .i_addr  (idx),
        .i_wdata ({r_head, r_count}),
        .o_rdata (hc_rdata)
    );

    swrl_ram #(.WIDTH(32), .DEPTH(KEY_ENTRIES * QUEUE_DEPTH)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append && (r_count < eff_max)),
        .i_addr  (st_addr),
        .i_wdata (r_now),
        .o_rdata (st_rdata)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_max  <= RST_AUTH_MAX;
            r_auth_win  <= RST_AUTH_WIN;
            r_api_max   <= RST_API_MAX;
            r_api_win   <= RST_API_WIN;
            r_clean_age <= RST_CLEAN_AGE;
            r_clean_per <= RST_CLEAN_PER;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_AUTH_MAX:  r_auth_max  <= i_cfg_wdata[7:0];
                REG_AUTH_WIN:  r_auth_win  <= i_cfg_wdata;
                REG_API_MAX:   r_api_max   <= i_cfg_wdata[7:0];
                REG_API_WIN:   r_api_win   <= i_cfg_wdata;
                REG_CLEAN_AGE: r_clean_age <= i_cfg_wdata;
                REG_CLEAN_PER: r_clean_per <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call_cnt  <= '0;
            r_sweep_due <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                if (next_cnt > {1'b0, r_clean_per}) begin
                    r_call_cnt  <= '0;
                    r_sweep_due <= 1'b1;
                end else begin
                    r_call_cnt  <= next_cnt[6:0];
                    r_sweep_due <= 1'b0;
                end
            end
            if (i_cmd.free_entry) begin
                r_valid[idx] <= 1'b0;
            end
            if (i_cmd.alloc) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_cls        <= i_limit_class;
            r_addr       <= i_client_address;
            r_now        <= i_now_ms;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_allowed    <= 1'b0;
            r_full       <= 1'b0;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.sel_hit) begin
            r_idx <= {1'b0, r_hit};
        end else if (i_cmd.sel_free) begin
            r_idx <= {1'b0, r_free};
        end
        if (i_cmd.key_cmp) begin
            if (cur_valid && !r_found && key_rdata == {r_cls, r_addr}) begin
                r_found <= 1'b1;
                r_hit   <= idx;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= idx;
            end
        end
        if (i_cmd.hc_load) begin
            r_head  <= hc_rdata[HC_W-1:CNT_W];
            r_count <= hc_rdata[CNT_W-1:0];
        end else if (i_cmd.alloc) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.pop) begin
            r_head  <= r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end else if (i_cmd.append && (r_count < eff_max)) begin
            r_count   <= r_count + 1'b1;
            r_allowed <= 1'b1;
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_allowed <= r_allowed;
            r_out_full    <= r_full;
            r_out_count   <= r_full ? 8'd0 : r_count;
        end
    end

    assign o_status.sweep_due  = r_sweep_due;
    assign o_status.idx_end    = (r_idx == (KEY_W+1)'(KEY_ENTRIES));
    assign o_status.cur_valid  = cur_valid;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.too_old    = (age > limit);
    assign o_status.found      = r_found;
    assign o_status.free_found = r_free_found;
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid           = r_out_valid;
    assign o_allowed         = r_out_allowed;
    assign o_table_full      = r_out_full;
    assign o_count_in_window = r_out_count;

`ifndef ASSERT_OFF
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append && r_count < eff_max) |-> (r_count < CNT_W'(QUEUE_DEPTH)))
        else $error("ring overflow");
    a_full_not_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_allowed && r_out_full))
        else $error("result both allowed and table full");
    a_alloc_free_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !cur_valid)
        else $error("allocating an entry already in use");
`endif

endmodule

>>> src/sliding_window_rate_limiter_unit.sv
// One request at a time: the input stalls from acceptance until the result is
// loaded into the output register, which waits until the previous result is taken; a
// sweep of all entries runs ahead of the lookup every period+1 requests.
// The key search walks every entry of the single-port key RAM for each request.
// Reset (sync, active low): entries free, call counter zero, config at defaults.
module sliding_window_rate_limiter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_limit_class,
    input  logic [31:0] i_client_address,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_allowed,
    output logic        o_table_full,
    output logic [7:0]  o_count_in_window
);
    import swrl_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: one request transfer in, walk the tables, one result out
    swrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // tables, config and result register; stamp/key memories need no clearing
    swrl_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_limit_class     (i_limit_class),
        .i_client_address  (i_client_address),
        .i_now_ms          (i_now_ms),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_allowed         (o_allowed),
        .o_table_full      (o_table_full),
        .o_count_in_window (o_count_in_window),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule

>>> tb/tb_sliding_window_rate_limiter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_rate_limiter_unit.
// Depends on swrl_pkg; checks every result against an in-bench model of the table.
module tb_sliding_window_rate_limiter_unit;
    import swrl_pkg::*;

    localparam logic CLASS_AUTH = 1'b0;
    localparam logic CLASS_API  = 1'b1;
    localparam int   WATCHDOG_LIMIT = 200000;
    localparam int   HOLD_CYCLES    = 600;

    typedef struct {
        logic        cls;
        logic [31:0] addr;
        logic [31:0] now;
    } t_request;

    typedef struct {
        logic       allowed;
        logic       full;
        logic [7:0] count;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_limit_class = 1'b0;
    logic [31:0] i_client_address = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic        o_allowed;
    logic        o_table_full;
    logic [7:0]  o_count_in_window;

    sliding_window_rate_limiter_unit dut (.*);

    // Model of the limiter: configuration and table state.
    logic [7:0]  m_auth_max, m_api_max;
    logic [31:0] m_auth_win, m_api_win, m_clean_age;
    logic [6:0]  m_clean_per;
    logic        m_used [KEY_ENTRIES];
    logic [32:0] m_key  [KEY_ENTRIES];
    logic [31:0] m_ring [KEY_ENTRIES][QUEUE_DEPTH];
    logic [6:0]  m_head [KEY_ENTRIES];
    logic [7:0]  m_cnt  [KEY_ENTRIES];
    logic [6:0]  m_calls;

    t_request pending_reqs[$];
    t_verdict expected_verdicts[$];

    int send_idle = 0;
    int recv_idle = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int mismatches = 0;
    int watchdog = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pop stamps from the front of an entry's ring while they are too old.
    function automatic void drop_stale(int e, logic [31:0] now, logic [31:0] lim);
        logic [31:0] age;
        while (m_cnt[e] > 0) begin
            age = now - m_ring[e][m_head[e]];
            if (age <= lim) break;
            m_head[e] = m_head[e] + 7'd1;
            m_cnt[e]  = m_cnt[e] - 8'd1;
        end
    endfunction

    // Work out the verdict for one accepted request and advance the model.
    function automatic t_verdict admit_request(t_request r);
        t_verdict    v;
        logic [32:0] key;
        logic [7:0]  lim_max;
        logic [31:0] win;
        logic [7:0]  next;
        int          hit, free_e;
        key     = {r.cls, r.addr};
        lim_max = r.cls ? m_api_max : m_auth_max;
        win     = r.cls ? m_api_win : m_auth_win;
        next    = {1'b0, m_calls} + 8'd1;
        hit     = KEY_ENTRIES;
        free_e  = KEY_ENTRIES;
        if (next > {1'b0, m_clean_per}) begin
            // Periodic sweep runs ahead of the lookup.
            for (int e = 0; e < KEY_ENTRIES; e++) begin
                if (m_used[e]) begin
                    drop_stale(e, r.now, m_clean_age);
                    if (m_cnt[e] == 0) begin
                        m_used[e] = 1'b0;
                        m_head[e] = '0;
                    end
                end
            end
            m_calls = '0;
        end else begin
            m_calls = next[6:0];
        end
        for (int e = 0; e < KEY_ENTRIES; e++) begin
            if (m_used[e]) begin
                if (hit == KEY_ENTRIES && m_key[e] == key) hit = e;
            end else if (free_e == KEY_ENTRIES) begin
                free_e = e;
            end
        end
        if (hit == KEY_ENTRIES) begin
            if (free_e == KEY_ENTRIES) begin
                v.allowed = 1'b0;
                v.full    = 1'b1;
                v.count   = '0;
                return v;
            end
            hit = free_e;
            m_used[hit] = 1'b1;
            m_key[hit]  = key;
            m_head[hit] = '0;
            m_cnt[hit]  = '0;
        end
        drop_stale(hit, r.now, win);
        if (lim_max > QUEUE_DEPTH) lim_max = 8'(QUEUE_DEPTH);
        v.allowed = 1'b0;
        if (m_cnt[hit] < lim_max) begin
            m_ring[hit][m_head[hit] + m_cnt[hit][6:0]] = r.now;
            m_cnt[hit] = m_cnt[hit] + 8'd1;
            v.allowed  = 1'b1;
        end
        v.full  = 1'b0;
        v.count = m_cnt[hit];
        return v;
    endfunction

    // Driver: hold a stalled transfer, otherwise offer the next pending request.
    always @(posedge i_clk) begin
        t_request cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cur.cls  = i_limit_class;
                cur.addr = i_client_address;
                cur.now  = i_now_ms;
                expected_verdicts.push_back(admit_request(cur));
                void'(pending_reqs.pop_front());
            end
            if (!(i_valid && o_stall)) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    i_valid          <= 1'b1;
                    i_limit_class    <= pending_reqs[0].cls;
                    i_client_address <= pending_reqs[0].addr;
                    i_now_ms         <= pending_reqs[0].now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: drive the output stall and check each result transfer.
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: allowed=%0d full=%0d count=%0d",
                             o_allowed, o_table_full, o_count_in_window);
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (o_allowed !== exp_v.allowed || o_table_full !== exp_v.full ||
                    o_count_in_window !== exp_v.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp allowed=%0d full=%0d count=%0d, got %0d %0d %0d",
                                 exp_v.allowed, exp_v.full, exp_v.count,
                                 o_allowed, o_table_full, o_count_in_window);
                end
            end
        end
        // A long hold-off lets the block fill up and stall its input.
        if (hold_req && hold_cnt == 0) hold_cnt = HOLD_CYCLES;
        if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_req = 0;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_AUTH_MAX:  m_auth_max  = val[7:0];
            REG_AUTH_WIN:  m_auth_win  = val;
            REG_API_MAX:   m_api_max   = val[7:0];
            REG_API_WIN:   m_api_win   = val;
            REG_CLEAN_AGE: m_clean_age = val;
            REG_CLEAN_PER: m_clean_per = val[6:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic push_req(logic cls, logic [31:0] addr, logic [31:0] now);
        t_request r;
        r.cls  = cls;
        r.addr = addr;
        r.now  = now;
        pending_reqs.push_back(r);
    endtask

    // Wait until everything offered has been answered, then let the block settle.
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_verdicts.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] am, logic [31:0] aw, logic [7:0] pm,
                             logic [31:0] pw, logic [31:0] age, logic [6:0] per);
        cfg_write(REG_AUTH_MAX, {24'd0, am});
        cfg_write(REG_AUTH_WIN, aw);
        cfg_write(REG_API_MAX, {24'd0, pm});
        cfg_write(REG_API_WIN, pw);
        cfg_write(REG_CLEAN_AGE, age);
        cfg_write(REG_CLEAN_PER, {25'd0, per});
    endtask

    // Mostly requests from a small client pool with advancing time; the rest is noise.
    task automatic random_phase(int n, int pool_size, int step_max, logic [31:0] t0);
        logic [31:0] pool [128];
        logic [31:0] t;
        t = t0;
        for (int k = 0; k < pool_size; k++) pool[k] = $urandom();
        pool[0] = 32'h0000_0000;
        if (pool_size > 1) pool[1] = 32'hFFFF_FFFF;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                push_req($urandom_range(0, 1), $urandom(), $urandom());
            end else begin
                t = t + $urandom_range(0, step_max);
                push_req($urandom_range(0, 1), pool[$urandom_range(0, pool_size - 1)], t);
            end
        end
    endtask

    initial begin
        m_auth_max  = RST_AUTH_MAX;
        m_auth_win  = RST_AUTH_WIN;
        m_api_max   = RST_API_MAX;
        m_api_win   = RST_API_WIN;
        m_clean_age = RST_CLEAN_AGE;
        m_clean_per = RST_CLEAN_PER;
        m_calls     = '0;
        for (int e = 0; e < KEY_ENTRIES; e++) begin
            m_used[e] = 1'b0;
            m_key[e]  = '0;
            m_head[e] = '0;
            m_cnt[e]  = '0;
            for (int q = 0; q < QUEUE_DEPTH; q++) m_ring[e][q] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: defaults, class maximum reached, address and time extremes.
        send_idle = 38;
        recv_idle = 66;
        for (int k = 0; k < 6; k++) push_req(CLASS_AUTH, 32'h0A00_0001, 32'd1000);
        push_req(CLASS_API, 32'h0000_0000, 32'h0000_0000);
        push_req(CLASS_API, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(CLASS_AUTH, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(CLASS_AUTH, 32'h0A00_0001, 32'd61001);   // all stamps expire
        push_req(CLASS_API, 32'h0000_0000, 32'd60000);    // age equal to window, kept
        push_req(CLASS_API, 32'h0000_0000, 32'd1);        // time steps back; oldest stamp age is 1
        drain();

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                send_idle = 66;
                recv_idle = 38;
            end else if (p == 8) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (p)
                // Small windows with frequent sweeps.
                0: configure(8'd3, 32'd100, 8'd8, 32'd300, 32'd1000, 7'd20);
                // Auth maximum of zero denies every auth request; API ring can fill to 128.
                1: configure(8'd0, 32'd50, 8'd128, 32'd1000, 32'd5000, 7'd126);
                // Maximum above ring depth, zero window, sweep on every request.
                2: configure(8'd255, 32'd2000, 8'd1, 32'd0, 32'd400, 7'd0);
                // Widest window, tiny cleanup age, longest period.
                3: configure(8'd2, 32'hFFFF_FFFF, 8'd6, 32'd1, 32'd1, 7'd127);
                // Entries never age out, so many clients fill the table.
                4: configure(8'd10, 32'd500, 8'd10, 32'd500, 32'hFFFF_FFFF, 7'd30);
                default: configure($urandom_range(0, 12), $urandom_range(1, 600),
                                   $urandom_range(0, 12), $urandom_range(1, 600),
                                   $urandom_range(1, 3000), $urandom_range(0, 127));
            endcase
            case (p)
                0: random_phase(150, 6, 20, $urandom());
                1: random_phase(300, 2, 3, $urandom());
                2: random_phase(150, 8, 5, $urandom());
                3: random_phase(150, 6, 50, 32'hFFFF_F000);
                4: random_phase(150, 90, 5, $urandom());
                default: random_phase(70, $urandom_range(2, 20), $urandom_range(1, 100),
                                      $urandom());
            endcase
            if (p == 2) hold_req = 1;
            if (p == 5) begin
                // Pause the sender until every result is in, then go on.
                drain();
                random_phase(70, 10, 40, $urandom());
            end
            drain();
        end

        configure(RST_AUTH_MAX, RST_AUTH_WIN, RST_API_MAX, RST_API_WIN,
                  RST_CLEAN_AGE, RST_CLEAN_PER);
        random_phase(330, 12, 2000, $urandom());
        drain();
        repeat (300) @(posedge i_clk);

        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sliding_window_rate_limiter_unit.f
src/swrl_pkg.sv
src/swrl_ram.sv
src/swrl_ctrl.sv
src/swrl_dp.sv
src/sliding_window_rate_limiter_unit.sv
tb/tb_sliding_window_rate_limiter_unit.sv
